// ===== hw/rtl/u8ds_pkg.sv =====
// ----------------------------------------------------------------------------
// u8ds_pkg
// Types, constants and helpers shared by the UTF-8 decoder/sanitizer blocks.
// ----------------------------------------------------------------------------
package u8ds_pkg;

    localparam int CP_W      = 21;
    localparam int MAX_CP_W  = 16;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SANITIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CP   = 1'b1;

    localparam logic [MAX_CP_W-1:0] MAX_CP_RESET = 16'd4096;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00fffd;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10ffff;
    localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00d800;
    localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00dfff;
    localparam logic [CP_W-1:0] CP_SPACE       = 21'h000020;
    localparam logic [CP_W-1:0] CP_DEL         = 21'h00007f;
    localparam logic [CP_W-1:0] CP_C1_LO       = 21'h000080;
    localparam logic [CP_W-1:0] CP_C1_HI       = 21'h00009f;
    localparam logic [CP_W-1:0] CP_TAB         = 21'h000009;
    localparam logic [CP_W-1:0] CP_LF          = 21'h00000a;
    localparam logic [CP_W-1:0] CP_CR          = 21'h00000d;
    localparam logic [CP_W-1:0] MIN_LEN2       = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3       = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4       = 21'h010000;

    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_PAT  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_PAT  = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_PAT  = 8'hf0;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last_in_run;
    } out_t;

    typedef struct packed {
        logic                sanitize;
        logic [MAX_CP_W-1:0] max_cp;
    } cfg_t;

    // Per-byte command: nrep replacement chars, then an optional code point,
    // then end-of-text handling when fin is set.
    typedef struct packed {
        logic [2:0]      nrep;
        logic            has_cp;
        logic [CP_W-1:0] cp;
        logic            fin;
    } cmd_t;

    // Emission plan: optional space, nrep U+FFFD, optional code point,
    // then spaces for anything after (the end-of-text flush).
    typedef struct packed {
        logic            pre;
        logic [2:0]      nrep;
        logic            x_kept;
        logic [CP_W-1:0] x_val;
    } plan_t;

    function automatic logic is_text_cp(logic [CP_W-1:0] cp);
        logic ok;
        ok = 1'b1;
        if (cp > CP_MAX)
            ok = 1'b0;
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
            ok = 1'b0;
        if (cp == CP_DEL || cp < CP_SPACE)
            ok = 1'b0;
        if (cp >= CP_C1_LO && cp <= CP_C1_HI)
            ok = 1'b0;
        return ok;
    endfunction

    function automatic logic [CP_W-1:0] plan_entry(plan_t p, logic [2:0] pos);
        logic [2:0]      pre3;
        logic [2:0]      rep_end;
        logic [CP_W-1:0] val;
        pre3    = {2'b00, p.pre};
        rep_end = pre3 + p.nrep;
        if (pos < pre3)
            val = CP_SPACE;
        else if (pos < rep_end)
            val = CP_REPLACEMENT;
        else if (p.x_kept && pos == rep_end)
            val = p.x_val;
        else
            val = CP_SPACE;
        return val;
    endfunction

endpackage

// ===== hw/rtl/u8ds_front.sv =====
// ----------------------------------------------------------------------------
// u8ds_front
// Byte decoder: tracks the open UTF-8 sequence and turns each byte into a
// command for the emission stage.
// ----------------------------------------------------------------------------
module u8ds_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  u8ds_pkg::in_t   in_data,
    output u8ds_pkg::cmd_t  cmd
);

    logic [2:0]                 seq_reg;
    logic [2:0]                 seq_next;
    logic [1:0]                 bt_reg;
    logic [1:0]                 bt_next;
    logic [u8ds_pkg::CP_W-1:0]  pv_reg;
    logic [u8ds_pkg::CP_W-1:0]  pv_next;

    logic [7:0]                 b;
    logic                       is_cont;
    logic [u8ds_pkg::CP_W-1:0]  pv_shift;
    logic [1:0]                 bt_inc;
    logic                       seq_done;
    logic [u8ds_pkg::CP_W-1:0]  min_val;
    logic                       bad_val;

    // decode of the byte taken as a lead
    logic                       st_has_cp;
    logic [u8ds_pkg::CP_W-1:0]  st_cp;
    logic [2:0]                 st_seq;
    logic [u8ds_pkg::CP_W-1:0]  st_pv;

    u8ds_pkg::cmd_t             c;

    assign b = in_data.text_byte;

    always_comb
    begin
        st_has_cp = 1'b0;
        st_cp     = '0;
        st_seq    = u8ds_pkg::SEQ_NONE;
        st_pv     = '0;
        if (b[7] == 1'b0)
        begin
            st_has_cp = 1'b1;
            st_cp     = {13'd0, b};
        end
        else if ((b & u8ds_pkg::LEAD2_MASK) == u8ds_pkg::LEAD2_PAT)
        begin
            st_seq = u8ds_pkg::SEQ_LEN2;
            st_pv  = {16'd0, b[4:0]};
        end
        else if ((b & u8ds_pkg::LEAD3_MASK) == u8ds_pkg::LEAD3_PAT)
        begin
            st_seq = u8ds_pkg::SEQ_LEN3;
            st_pv  = {17'd0, b[3:0]};
        end
        else if ((b & u8ds_pkg::LEAD4_MASK) == u8ds_pkg::LEAD4_PAT)
        begin
            st_seq = u8ds_pkg::SEQ_LEN4;
            st_pv  = {18'd0, b[2:0]};
        end
        else
        begin
            // stray continuation or invalid lead
            st_has_cp = 1'b1;
            st_cp     = u8ds_pkg::CP_REPLACEMENT;
        end
    end

    always_comb
    begin
        is_cont  = (b & u8ds_pkg::CONT_MASK) == u8ds_pkg::CONT_PAT;
        pv_shift = {pv_reg[14:0], b[5:0]};
        bt_inc   = bt_reg + 2'd1;
        seq_done = ({1'b0, bt_inc} + 3'd1) >= seq_reg;
        case (seq_reg)
            u8ds_pkg::SEQ_LEN2: min_val = u8ds_pkg::MIN_LEN2;
            u8ds_pkg::SEQ_LEN3: min_val = u8ds_pkg::MIN_LEN3;
            default:            min_val = u8ds_pkg::MIN_LEN4;
        endcase
        bad_val = (pv_shift < min_val) || (pv_shift > u8ds_pkg::CP_MAX)
               || (pv_shift >= u8ds_pkg::CP_SURR_LO && pv_shift <= u8ds_pkg::CP_SURR_HI);

        seq_next = seq_reg;
        bt_next  = bt_reg;
        pv_next  = pv_reg;
        c        = '0;
        c.fin    = in_data.final_byte;

        if (seq_reg != u8ds_pkg::SEQ_NONE)
        begin
            if (!is_cont)
            begin
                // broken sequence: flush it, then redo this byte as a lead
                c.nrep   = {1'b0, bt_reg} + 3'd1;
                c.has_cp = st_has_cp;
                c.cp     = st_cp;
                seq_next = st_seq;
                bt_next  = 2'd0;
                pv_next  = st_pv;
            end
            else if (!seq_done)
            begin
                pv_next = pv_shift;
                bt_next = bt_inc;
            end
            else
            begin
                if (bad_val)
                    c.nrep = {1'b0, bt_inc} + 3'd1;
                else
                begin
                    c.has_cp = 1'b1;
                    c.cp     = pv_shift;
                end
                seq_next = u8ds_pkg::SEQ_NONE;
                bt_next  = 2'd0;
                pv_next  = '0;
            end
        end
        else
        begin
            c.has_cp = st_has_cp;
            c.cp     = st_cp;
            seq_next = st_seq;
            bt_next  = 2'd0;
            pv_next  = st_pv;
        end

        if (in_data.final_byte)
        begin
            // truncated sequence at end of text
            if (seq_next != u8ds_pkg::SEQ_NONE)
                c.nrep = c.nrep + {1'b0, bt_next} + 3'd1;
            seq_next = u8ds_pkg::SEQ_NONE;
            bt_next  = 2'd0;
            pv_next  = '0;
        end
    end

    assign cmd = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= u8ds_pkg::SEQ_NONE;
            bt_reg  <= 2'd0;
            pv_reg  <= '0;
        end
        else if (accept)
        begin
            seq_reg <= seq_next;
            bt_reg  <= bt_next;
            pv_reg  <= pv_next;
        end
    end

endmodule

// ===== hw/rtl/u8ds_queue.sv =====
// ----------------------------------------------------------------------------
// u8ds_queue
// Small command FIFO between the byte decoder and the emission stage.
// ----------------------------------------------------------------------------
module u8ds_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u8ds_pkg::cmd_t  wr_data,
    output logic            full,
    input  logic            pop,
    output logic            rd_valid,
    output u8ds_pkg::cmd_t  rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8ds_pkg::cmd_t  mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = count_reg == CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hw/rtl/u8ds_back.sv =====
// ----------------------------------------------------------------------------
// u8ds_back
// Emission stage: applies sanitizing and the code point limit to each
// command and drains the resulting code points one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module u8ds_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  u8ds_pkg::cfg_t  cfg,
    input  logic            cmd_valid,
    input  u8ds_pkg::cmd_t  cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output u8ds_pkg::out_t  out_data
);

    u8ds_pkg::plan_t                plan_reg;
    u8ds_pkg::plan_t                plan_next;
    logic [2:0]                     len_reg;
    logic [2:0]                     len_next;
    logic [2:0]                     pos_reg;
    logic [2:0]                     pos_next;
    logic                           pend_reg;
    logic                           pend_next;
    logic                           prev_reg;
    logic                           prev_next;
    logic [u8ds_pkg::MAX_CP_W-1:0]  cnt_reg;
    logic [u8ds_pkg::MAX_CP_W-1:0]  cnt_next;

    logic                           fold;
    logic                           x_kept;
    logic                           any_text;
    logic                           pre;
    logic                           pend1;
    logic                           prev1;
    logic                           post;
    logic [2:0]                     len_full;
    logic [u8ds_pkg::MAX_CP_W-1:0]  avail;
    logic [2:0]                     n_emit;
    logic [u8ds_pkg::CP_W-1:0]      last_cp;
    logic                           out_fire;
    logic                           drain_done;
    logic                           load;

    assign out_valid            = pos_reg != len_reg;
    assign out_fire             = out_valid && !out_stall;
    assign out_data.code_point  = u8ds_pkg::plan_entry(plan_reg, pos_reg);
    assign out_data.last_in_run = pos_reg == (len_reg - 3'd1);

    assign drain_done = !out_valid || (out_fire && pos_reg == (len_reg - 3'd1));
    assign load       = cmd_valid && drain_done;
    assign pop        = load;

    // plan for the command at the queue head
    always_comb
    begin
        fold = cfg.sanitize && cmd.has_cp
            && (cmd.cp == u8ds_pkg::CP_CR || cmd.cp == u8ds_pkg::CP_LF
                || cmd.cp == u8ds_pkg::CP_TAB);
        x_kept   = cmd.has_cp && !fold && (!cfg.sanitize || u8ds_pkg::is_text_cp(cmd.cp));
        any_text = (cmd.nrep != 3'd0) || x_kept;
        pre      = pend_reg && !prev_reg && any_text;
        pend1    = fold ? 1'b1 : (any_text ? 1'b0 : pend_reg);
        if (x_kept)
            prev1 = cmd.cp == u8ds_pkg::CP_SPACE;
        else if (cmd.nrep != 3'd0)
            prev1 = 1'b0;
        else
            prev1 = prev_reg;
        post     = cmd.fin && pend1 && !prev1;
        len_full = {2'b00, pre} + cmd.nrep + {2'b00, x_kept} + {2'b00, post};

        avail  = (cnt_reg >= cfg.max_cp) ? '0 : (cfg.max_cp - cnt_reg);
        n_emit = ({13'd0, len_full} > avail) ? avail[2:0] : len_full;

        plan_next.pre    = pre;
        plan_next.nrep   = cmd.nrep;
        plan_next.x_kept = x_kept;
        plan_next.x_val  = cmd.cp;

        last_cp = u8ds_pkg::plan_entry(plan_next, n_emit - 3'd1);
    end

    always_comb
    begin
        len_next  = len_reg;
        pos_next  = pos_reg;
        pend_next = pend_reg;
        prev_next = prev_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            len_next = n_emit;
            pos_next = 3'd0;
            if (cmd.fin)
            begin
                pend_next = 1'b0;
                prev_next = 1'b0;
                cnt_next  = '0;
            end
            else
            begin
                pend_next = pend1;
                // only code points actually sent count for the space rule
                prev_next = (n_emit == 3'd0) ? prev_reg : (last_cp == u8ds_pkg::CP_SPACE);
                cnt_next  = cnt_reg + {13'd0, n_emit};
            end
        end
        else if (out_fire)
            pos_next = pos_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= 3'd0;
            pos_reg  <= 3'd0;
            pend_reg <= 1'b0;
            prev_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
            prev_reg <= prev_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            plan_reg <= plan_next;
    end

endmodule

// ===== hw/rtl/utf8_decoder_sanitizer_top.sv =====
// Path: an accepted byte's command is written into the command queue, then
// loaded into the emitter's plan register, from which its code points are offered.
// Throughput: one byte per cycle while each byte yields at most one code point
// and out_stall is low; a byte with k code points (k up to 5) sends them in turn.
// The command queue between decoder and emitter is QUEUE_DEPTH entries deep.
// Reset: decoder, space tracking and count clear at once; sanitize off, limit 4096.
// ----------------------------------------------------------------------------
// utf8_decoder_sanitizer_top
// Streaming UTF-8 decoder with optional whitespace folding, control stripping
// and a per-text code point limit.
// ----------------------------------------------------------------------------
module utf8_decoder_sanitizer_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  u8ds_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output u8ds_pkg::out_t                     out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [u8ds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [u8ds_pkg::MAX_CP_W-1:0]      cfg_data
);

    logic                           sanitize_reg;
    logic                           sanitize_next;
    logic [u8ds_pkg::MAX_CP_W-1:0]  max_cp_reg;
    logic [u8ds_pkg::MAX_CP_W-1:0]  max_cp_next;
    u8ds_pkg::cfg_t                 cfg;

    logic                           q_full;
    logic                           in_accept;
    u8ds_pkg::cmd_t                 front_cmd;
    logic                           head_valid;
    u8ds_pkg::cmd_t                 head_cmd;
    logic                           head_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        sanitize_next = sanitize_reg;
        max_cp_next   = max_cp_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                u8ds_pkg::REG_SANITIZE: sanitize_next = cfg_data[0];
                u8ds_pkg::REG_MAX_CP:   max_cp_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sanitize_reg <= 1'b0;
            max_cp_reg   <= u8ds_pkg::MAX_CP_RESET;
        end
        else
        begin
            sanitize_reg <= sanitize_next;
            max_cp_reg   <= max_cp_next;
        end
    end

    assign cfg.sanitize = sanitize_reg;
    assign cfg.max_cp   = max_cp_reg;

    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    u8ds_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_data (in_data),
        .cmd     (front_cmd)
    );

    u8ds_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept),
        .wr_data  (front_cmd),
        .full     (q_full),
        .pop      (head_pop),
        .rd_valid (head_valid),
        .rd_data  (head_cmd)
    );

    u8ds_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .pop       (head_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // never a surrogate or out-of-range scalar on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.code_point <= u8ds_pkg::CP_MAX)
            && !(out_data.code_point >= u8ds_pkg::CP_SURR_LO
                 && out_data.code_point <= u8ds_pkg::CP_SURR_HI))
        else $error("illegal scalar value on output");

    // a transaction that is not the last of its byte is followed by more
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_in_run |=> out_valid)
        else $error("result run ended without last_in_run");

endmodule
